/* design/bdpt_pkg.sv */
package bdpt_pkg;

    localparam int TIME_WIDTH = 32;
    localparam int SETTLE_WIDTH = 16;
    localparam int DURATION_WIDTH = 32;
    localparam logic [SETTLE_WIDTH-1:0] SETTLE_RESET = SETTLE_WIDTH'(40);

    typedef enum logic [1:0] {
        PH_UP      = 2'd0,
        PH_FALLING = 2'd1,
        PH_DOWN    = 2'd2,
        PH_RISING  = 2'd3
    } t_phase;

    typedef struct packed {
        logic                      is_down;
        logic                      press_event;
        logic                      release_event;
        logic                      duration_valid;
        logic [DURATION_WIDTH-1:0] press_duration;
    } t_result;

endpackage

/* design/bdpt_core.sv */
module bdpt_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [bdpt_pkg::SETTLE_WIDTH-1:0]    i_cfg_wr_data,
    input  logic                                 i_accept,
    input  logic                                 i_pin_level,
    output bdpt_pkg::t_result                    o_result
);
    import bdpt_pkg::*;

    t_phase                  r_phase;
    t_phase                  n_phase;
    logic [SETTLE_WIDTH-1:0] r_settle_ticks;
    logic [SETTLE_WIDTH-1:0] r_settle_count;
    logic [SETTLE_WIDTH-1:0] n_settle_count;
    logic [TIME_WIDTH-1:0]   r_tick_now;
    logic [TIME_WIDTH-1:0]   r_press_stamp;
    logic [TIME_WIDTH-1:0]   n_press_stamp;
    logic [TIME_WIDTH-1:0]   elapsed;
    logic [63:0]             elapsed_ext;
    logic                    pressed;
    logic                    settled;
    logic                    press_ev;
    logic                    release_ev;

    assign pressed     = ~i_pin_level;
    assign settled     = r_settle_count >= r_settle_ticks;
    assign elapsed     = r_tick_now - r_press_stamp;
    assign elapsed_ext = 64'(elapsed);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ticks <= SETTLE_RESET;
        end else if (i_cfg_wr_en) begin
            r_settle_ticks <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_UP;
            r_settle_count <= '0;
            r_tick_now     <= '0;
            r_press_stamp  <= '0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_settle_count <= n_settle_count;
            r_tick_now     <= r_tick_now + TIME_WIDTH'(1);
            r_press_stamp  <= n_press_stamp;
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_settle_count = r_settle_count;
        n_press_stamp  = r_press_stamp;
        press_ev       = 1'b0;
        release_ev     = 1'b0;
        case (r_phase)
            PH_UP: begin
                if (pressed) begin
                    n_phase = PH_FALLING;
                end
            end
            PH_FALLING: begin
                if (settled) begin
                    n_settle_count = '0;
                    if (pressed) begin
                        n_phase       = PH_DOWN;
                        n_press_stamp = r_tick_now;
                        press_ev      = 1'b1;
                    end else begin
                        n_phase = PH_UP;
                    end
                end else begin
                    n_settle_count = r_settle_count + SETTLE_WIDTH'(1);
                end
            end
            PH_DOWN: begin
                if (!pressed) begin
                    n_phase = PH_RISING;
                end
            end
            PH_RISING: begin
                if (settled) begin
                    n_settle_count = '0;
                    if (!pressed) begin
                        n_phase    = PH_UP;
                        release_ev = 1'b1;
                    end else begin
                        n_phase = PH_DOWN;
                    end
                end else begin
                    n_settle_count = r_settle_count + SETTLE_WIDTH'(1);
                end
            end
            default: begin
                n_phase = PH_UP;
            end
        endcase
    end

    always_comb begin
        o_result.is_down        = (n_phase == PH_DOWN) || (n_phase == PH_RISING);
        o_result.press_event    = press_ev;
        o_result.release_event  = release_ev;
        o_result.press_duration = release_ev ? elapsed_ext[DURATION_WIDTH-1:0] : '0;
        o_result.duration_valid = release_ev && (elapsed_ext[DURATION_WIDTH-1:0] != '0);
    end

endmodule

/* design/bdpt_out_reg.sv */
module bdpt_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  bdpt_pkg::t_result i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output bdpt_pkg::t_result o_data
);
    import bdpt_pkg::*;

    logic    r_valid;
    t_result r_data;
    logic    load;

    assign load    = !r_valid || !i_stall;
    assign o_stall = !load;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

/* design/button_debounce_press_timer.sv */
// The result of a request appears on the output in the cycle after it is accepted.
// Throughput: one request per cycle while the output is not stalled; the debounce state update
// and the duration subtract are combinational, ahead of the output register.
// Reset: synchronous, active low. The phase returns to up, the settle count, tick counter and
// press stamp clear to zero, the settle time returns to 40 ticks and the output empties.
module button_debounce_press_timer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [bdpt_pkg::SETTLE_WIDTH-1:0] i_cfg_wr_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_pin_level,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_is_down,
    output logic                              o_press_event,
    output logic                              o_release_event,
    output logic                              o_duration_valid,
    output logic [bdpt_pkg::DURATION_WIDTH-1:0] o_press_duration
);
    import bdpt_pkg::*;

    t_result core_result;
    t_result out_result;
    logic    accept;

    assign accept = i_in_valid && !o_in_stall;

    bdpt_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_pin_level   (i_pin_level),
        .o_result      (core_result)
    );

    bdpt_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (core_result),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_result)
    );

    assign o_is_down        = out_result.is_down;
    assign o_press_event    = out_result.press_event;
    assign o_release_event  = out_result.release_event;
    assign o_duration_valid = out_result.duration_valid;
    assign o_press_duration = out_result.press_duration;

endmodule
